>>> hdl/putf_pkg.sv
// Package for the paired device table with frame filter.
// Holds the shared types, codes and sizing constants; depends on nothing.
package putf_pkg;

    // Table sizing
    localparam int TABLE_DEPTH = 8;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int COUNT_MAX   = 15;
    localparam int COUNT_FULL  = (TABLE_DEPTH < COUNT_MAX) ? TABLE_DEPTH : COUNT_MAX;

    // Item kinds
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;
    localparam logic [1:0] KIND_FILTER = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_PRESENT = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_ABSENT  = 3'd3;
    localparam logic [2:0] ST_REJECT  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_OWN_UID  = 2'd0;
    localparam logic [1:0] REG_DISC_MSG = 2'd1;
    localparam logic [1:0] REG_DISC_ACK = 2'd2;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_FINISH
    } seq_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] device_uid;
        logic [31:0] dest_uid;
        logic [7:0]  frame_type;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] slot_index;
        logic [3:0] paired_count;
    } out_item_t;

    typedef struct packed {
        logic [31:0] own_uid;
        logic [7:0]  disc_msg_code;
        logic [7:0]  disc_ack_code;
    } cfg_t;

    // Write command from the sequencer to the table
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [31:0]      data;
    } tbl_wr_t;

    // Compare flags from the table for the entry being scanned
    typedef struct packed {
        logic match;
        logic empty;
    } tbl_flags_t;

endpackage

>>> hdl/putf_table.sv
// Table of paired device IDs with the shared compare unit.
// One entry is compared per cycle at the scan index. Depends on putf_pkg.
module putf_table (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [putf_pkg::IDX_W-1:0] scan_idx,
    input  logic [31:0]               key,
    input  putf_pkg::tbl_wr_t         wr,
    output putf_pkg::tbl_flags_t      flags
);
    import putf_pkg::*;

    logic [31:0] ids_reg [TABLE_DEPTH];
    logic [31:0] entry;

    // Storage: every slot reads as empty after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                ids_reg[i] <= '0;
            end
        end
        else if (wr.we)
        begin
            ids_reg[wr.addr] <= wr.data;
        end
    end

    // Shared compare unit on the selected entry.
    always_comb
    begin
        entry       = ids_reg[scan_idx];
        flags.match = (entry == key);
        flags.empty = (entry == '0);
    end

endmodule

>>> hdl/putf_seq.sv
// Sequencer: takes one transaction, scans the table a slot per cycle and
// forms the result and table update. Depends on putf_pkg.
module putf_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  putf_pkg::in_item_t         in_item,
    input  putf_pkg::cfg_t             cfg,
    input  putf_pkg::tbl_flags_t       flags,
    output logic [putf_pkg::IDX_W-1:0] scan_idx,
    output logic [31:0]                key,
    output putf_pkg::tbl_wr_t          wr,
    input  logic                       out_free,
    output logic                       res_load,
    output putf_pkg::out_item_t        res
);
    import putf_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    seq_state_t       state_reg, state_next;
    in_item_t         item_reg, item_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             emp_reg, emp_next;
    logic [IDX_W-1:0] emp_idx_reg, emp_idx_next;
    logic [3:0]       count_reg, count_next;

    logic             disc;
    logic [IDX_W-1:0] slot;

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
            emp_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            hit_reg   <= hit_next;
            emp_reg   <= emp_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        hit_idx_reg <= hit_idx_next;
        emp_idx_reg <= emp_idx_next;
    end

    assign scan_idx = idx_reg;
    assign key      = item_reg.device_uid;

    // Next state, scan bookkeeping and result.
    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        emp_next     = emp_reg;
        emp_idx_next = emp_idx_reg;
        count_next   = count_reg;
        in_ready     = 1'b0;
        res_load     = 1'b0;
        wr           = '0;
        slot         = '0;
        res          = '0;
        disc         = (item_reg.frame_type == cfg.disc_msg_code) ||
                       (item_reg.frame_type == cfg.disc_ack_code);

        unique case (state_reg)
            SEQ_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next  = in_item;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    emp_next   = 1'b0;
                    state_next = SEQ_SCAN;
                end
            end

            SEQ_SCAN:
            begin
                // Zero is the empty marker and never matches a paired device.
                if (flags.match && (item_reg.device_uid != '0) && !hit_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_reg;
                end
                if (flags.empty && !emp_reg)
                begin
                    emp_next     = 1'b1;
                    emp_idx_next = idx_reg;
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = SEQ_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            SEQ_FINISH:
            begin
                res.status = ST_OK;
                unique case (item_reg.kind)
                    KIND_ADD:
                    begin
                        if (item_reg.device_uid == '0)
                        begin
                            res.status = ST_REJECT;
                        end
                        else if (hit_reg)
                        begin
                            res.status = ST_PRESENT;
                            slot       = hit_idx_reg;
                        end
                        else if (!emp_reg)
                        begin
                            res.status = ST_FULL;
                        end
                        else
                        begin
                            wr.we   = out_free;
                            wr.addr = emp_idx_reg;
                            wr.data = item_reg.device_uid;
                            slot    = emp_idx_reg;
                            if (count_reg != 4'(COUNT_MAX))
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end

                    KIND_REMOVE:
                    begin
                        if (!hit_reg)
                        begin
                            res.status = ST_ABSENT;
                        end
                        else
                        begin
                            wr.we   = out_free;
                            wr.addr = hit_idx_reg;
                            wr.data = '0;
                            slot    = hit_idx_reg;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                    end

                    KIND_LOOKUP:
                    begin
                        if (!hit_reg)
                        begin
                            res.status = ST_ABSENT;
                        end
                        else
                        begin
                            slot = hit_idx_reg;
                        end
                    end

                    KIND_FILTER:
                    begin
                        if (hit_reg)
                        begin
                            slot = hit_idx_reg;
                        end
                        if ((item_reg.dest_uid == cfg.own_uid) && (disc || hit_reg))
                        begin
                            res.status = ST_OK;
                        end
                        else
                        begin
                            res.status = ST_REJECT;
                        end
                    end

                    default:
                    begin
                        res.status = ST_REJECT;
                    end
                endcase

                res.slot_index   = 3'(slot);
                res.paired_count = count_next;

                // Hold here until the output register can take the result.
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = SEQ_IDLE;
                end
                else
                begin
                    count_next = count_reg;
                end
            end

            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/paired_uid_table_with_filter_top.sv
// Top level of the paired device table with frame filter.
// Holds the configuration registers and output register; depends on putf_pkg,
// putf_table and putf_seq.
//
// Usage:
// - Input channel in_valid / in_ready / in_item carries one request per
//   transaction: add, remove, lookup or frame filter.
// - Output channel out_valid / out_ready / out_item returns exactly one result
//   per request, in order.
// - Configuration is written through cfg_we / cfg_index / cfg_wdata; index 0 is
//   the own ID, 1 the discovery request code, 2 the discovery acknowledgement
//   code. Other indexes are ignored.
// - A request's result is loaded into the output register after the scan: each
//   slot in turn through the shared compare unit (SEQ_SCAN), then a finish step
//   (SEQ_FINISH). The block takes a new request only after that load, back in
//   SEQ_IDLE, so it handles one request at a time.
// - A finished result waits in the output register; if the receiver stalls,
//   a following request is scanned and then held until the register frees.
// - Reset empties every slot, clears the paired count and the output valid flag,
//   and loads the configuration reset values.
module paired_uid_table_with_filter_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  putf_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output putf_pkg::out_item_t out_item
);
    import putf_pkg::*;

    cfg_t             cfg_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;
    tbl_flags_t       flags;
    tbl_wr_t          wr;
    logic [IDX_W-1:0] scan_idx;
    logic [31:0]      key;
    logic             out_free;
    logic             res_load;
    out_item_t        res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_uid       <= 32'd0;
            cfg_reg.disc_msg_code <= 8'd0;
            cfg_reg.disc_ack_code <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OWN_UID:  cfg_reg.own_uid       <= cfg_wdata;
                REG_DISC_MSG: cfg_reg.disc_msg_code <= cfg_wdata[7:0];
                REG_DISC_ACK: cfg_reg.disc_ack_code <= cfg_wdata[7:0];
                default:      ;
            endcase
        end
    end

    // Output register: free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_item_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    putf_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .scan_idx (scan_idx),
        .key      (key),
        .wr       (wr),
        .flags    (flags)
    );

    putf_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .cfg      (cfg_reg),
        .flags    (flags),
        .scan_idx (scan_idx),
        .key      (key),
        .wr       (wr),
        .out_free (out_free),
        .res_load (res_load),
        .res      (res)
    );

`ifndef ASSERT_OFF
    // A transaction taken in starts a scan, so the block is busy next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted on consecutive cycles");

    // A full table answer comes only with every slot paired.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.status == ST_FULL)) |->
        (out_item.paired_count == 4'(COUNT_FULL)))
        else $error("table full reported with a short paired count");

    // The paired count never exceeds the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.paired_count <= 4'(COUNT_FULL)))
        else $error("paired count beyond table depth");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for paired_uid_table_with_filter_top.
// Holds a scoreboard class with its own model of the paired ID table and plain driver tasks.
// Depends on putf_pkg and the top level of the block only.
`timescale 1ns / 100ps

module tb;

    import putf_pkg::*;

    // Index with no register behind it; a write there must change nothing
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int         POOL_SIZE  = 12;
    localparam int         SEG_COUNT  = 6;
    localparam int         SEG_ITEMS  = 255;
    // Drain wait: long enough for a request to pass through the block, with a margin on top
    localparam int         SETTLE     = TABLE_DEPTH + 8;

    // Tracks the paired table and the filter settings, and holds the results still awaited
    class pairing_scoreboard;
        logic [31:0] slot_uid [TABLE_DEPTH];
        logic [3:0]  entry_total;
        logic [31:0] own_id;
        logic [7:0]  disc_req;
        logic [7:0]  disc_ack;
        out_item_t   awaited [$];
        int unsigned errors;

        function new();
            foreach (slot_uid[i])
                slot_uid[i] = '0;
            entry_total = '0;
            own_id      = '0;
            disc_req    = 8'd0;
            disc_ack    = 8'd1;
            errors      = 0;
        endfunction

        function void write_register(logic [1:0] index, logic [31:0] value);
            case (index)
                REG_OWN_UID:  own_id   = value;
                REG_DISC_MSG: disc_req = value[7:0];
                REG_DISC_ACK: disc_ack = value[7:0];
                default: ;
            endcase
        endfunction

        // Slot holding this ID, or -1; zero is the empty marker and never matches
        function int match_slot(logic [31:0] id);
            if (id == '0)
                return -1;
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (slot_uid[i] == id)
                    return i;
            return -1;
        endfunction

        function int empty_slot();
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (slot_uid[i] == '0)
                    return i;
            return -1;
        endfunction

        // Works out the result of one accepted request and updates the table
        function void note_request(in_item_t req);
            out_item_t res;
            int        hit;
            int        free_slot;
            logic      disc;
            res = '0;
            hit = match_slot(req.device_uid);
            case (req.kind)
                KIND_ADD:
                begin
                    if (req.device_uid == '0)
                        res.status = ST_REJECT;
                    else if (hit >= 0)
                    begin
                        res.status     = ST_PRESENT;
                        res.slot_index = hit[2:0];
                    end
                    else
                    begin
                        free_slot = empty_slot();
                        if (free_slot < 0)
                            res.status = ST_FULL;
                        else
                        begin
                            slot_uid[free_slot] = req.device_uid;
                            if (entry_total < COUNT_MAX)
                                entry_total = entry_total + 4'd1;
                            res.status     = ST_OK;
                            res.slot_index = free_slot[2:0];
                        end
                    end
                end
                KIND_REMOVE:
                begin
                    if (hit < 0)
                        res.status = ST_ABSENT;
                    else
                    begin
                        slot_uid[hit] = '0;
                        if (entry_total > 0)
                            entry_total = entry_total - 4'd1;
                        res.status     = ST_OK;
                        res.slot_index = hit[2:0];
                    end
                end
                KIND_LOOKUP:
                begin
                    if (hit < 0)
                        res.status = ST_ABSENT;
                    else
                    begin
                        res.status     = ST_OK;
                        res.slot_index = hit[2:0];
                    end
                end
                default:
                begin
                    // Frame filter: addressed to us, and either discovery traffic or a paired source
                    disc = (req.frame_type == disc_req) || (req.frame_type == disc_ack);
                    if (hit >= 0)
                        res.slot_index = hit[2:0];
                    if (req.dest_uid == own_id && (disc || hit >= 0))
                        res.status = ST_OK;
                    else
                        res.status = ST_REJECT;
                end
            endcase
            res.paired_count = entry_total;
            awaited.push_back(res);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            if (awaited.size() == 0)
            begin
                $error("unexpected result transaction: status %0d slot %0d count %0d",
                       got.status, got.slot_index, got.paired_count);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            if (got.status !== exp.status)
            begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.slot_index !== exp.slot_index)
            begin
                $error("slot_index: expected %0d, got %0d", exp.slot_index, got.slot_index);
                errors++;
            end
            if (got.paired_count !== exp.paired_count)
            begin
                $error("paired_count: expected %0d, got %0d",
                       exp.paired_count, got.paired_count);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_item;

    pairing_scoreboard book = new();

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    logic [31:0] uid_pool [POOL_SIZE];

    paired_uid_table_with_filter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // Clock generation
    initial
        clk = 1'b0;
    always
        #4 clk = ~clk;

    // Overall limit, well beyond what a correct run needs
    initial
    begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

    // Receiver: checks each result transaction and stalls at random
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                book.check_result(out_item);
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Presents one request, with an optional gap first, and waits for its transaction
    task automatic send_request(input in_item_t req);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        book.note_request(req);
    endtask

    task automatic send_fields(input logic [1:0] kind, input logic [31:0] uid,
                               input logic [31:0] dest, input logic [7:0] ftype);
        in_item_t req;
        req.kind       = kind;
        req.device_uid = uid;
        req.dest_uid   = dest;
        req.frame_type = ftype;
        send_request(req);
    endtask

    // Drops valid and lets the block drain completely before any register write
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Writes all three registers and then the unused index, one per cycle
    task automatic write_settings(input logic [31:0] own, input logic [7:0] req_code,
                                  input logic [7:0] ack_code);
        logic [1:0]  idx [4];
        logic [31:0] val [4];
        idx[0] = REG_OWN_UID;  val[0] = own;
        idx[1] = REG_DISC_MSG; val[1] = {24'($urandom_range(32'hFFFFFF)), req_code};
        idx[2] = REG_DISC_ACK; val[2] = {24'($urandom_range(32'hFFFFFF)), ack_code};
        idx[3] = REG_UNUSED;   val[3] = $urandom;
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge clk);
            book.write_register(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic void refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            uid_pool[i] = $urandom;
            if (uid_pool[i] == '0)
                uid_pool[i] = 32'd1;
        end
    endfunction

    // Mostly table traffic on a small set of IDs so that the table fills and empties;
    // a few requests are entirely random
    function automatic in_item_t random_request();
        in_item_t    req;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            req.kind       = 2'($urandom_range(3));
            req.device_uid = $urandom;
            req.dest_uid   = $urandom;
            req.frame_type = 8'($urandom_range(255));
            return req;
        end
        if (pick < 38)
            req.kind = KIND_ADD;
        else if (pick < 62)
            req.kind = KIND_REMOVE;
        else if (pick < 76)
            req.kind = KIND_LOOKUP;
        else
            req.kind = KIND_FILTER;
        pick = $urandom_range(99);
        if (pick < 86)
            req.device_uid = uid_pool[4'($urandom_range(POOL_SIZE - 1))];
        else if (pick < 94)
            req.device_uid = $urandom;
        else
            req.device_uid = '0;
        req.dest_uid = ($urandom_range(99) < 75) ? book.own_id : $urandom;
        pick = $urandom_range(99);
        if (pick < 35)
            req.frame_type = book.disc_req;
        else if (pick < 55)
            req.frame_type = book.disc_ack;
        else
            req.frame_type = 8'($urandom_range(255));
        return req;
    endfunction

    // Main sequence
    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        in_item     = '0;
        tx_idle_pct = 10;
        rx_idle_pct = 54;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings: own ID 0, discovery codes 0 and 1
        send_fields(KIND_LOOKUP, 32'h0, 32'h0, 8'h00);
        send_fields(KIND_REMOVE, 32'h0, 32'h0, 8'h00);
        send_fields(KIND_ADD, 32'h0, 32'h0, 8'h00);
        send_fields(KIND_FILTER, 32'h0, 32'h0, 8'h00);
        send_fields(KIND_FILTER, 32'h0, 32'h0, 8'h02);
        send_fields(KIND_ADD, 32'hFFFF_FFFF, 32'h0, 8'h00);
        send_fields(KIND_ADD, 32'hFFFF_FFFF, 32'h0, 8'h00);
        for (int i = 1; i < TABLE_DEPTH; i++)
            send_fields(KIND_ADD, i, 32'h0, 8'h00);
        // Table is now full
        send_fields(KIND_ADD, 32'h8000_0000, 32'h0, 8'h00);
        send_fields(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 8'h00);
        send_fields(KIND_FILTER, 32'hFFFF_FFFF, 32'h0, 8'hFF);
        send_fields(KIND_FILTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h01);
        send_fields(KIND_REMOVE, 32'd3, 32'h0, 8'h00);
        send_fields(KIND_LOOKUP, 32'd3, 32'h0, 8'h00);
        send_fields(KIND_ADD, 32'h1234_5678, 32'h0, 8'h00);
        send_fields(KIND_REMOVE, 32'hDEAD_BEEF, 32'h0, 8'h00);
        send_fields(KIND_FILTER, 32'd5, 32'h0, 8'hFF);
        send_fields(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0, 8'h00);

        // Random part: six segments, each with its own settings; the idling mode changes every two segments
        for (int seg = 0; seg < SEG_COUNT; seg++)
        begin
            wait_idle();
            case (seg)
                1:       write_settings(32'hFFFF_FFFF, 8'hFF, 8'hFF);
                2:       write_settings(32'h0, 8'h00, 8'h00);
                4:       write_settings($urandom, 8'hFF, 8'h00);
                default: write_settings($urandom, 8'($urandom_range(255)),
                                        8'($urandom_range(255)));
            endcase
            if (seg < 2)
            begin
                tx_idle_pct = 10;
                rx_idle_pct = 54;
            end
            else if (seg < 4)
            begin
                tx_idle_pct = 54;
                rx_idle_pct = 10;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            refresh_pool();
            for (int n = 0; n < SEG_ITEMS; n++)
                send_request(random_request());
        end

        // Drain and finish
        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (2 * SETTLE) @(posedge clk);
        if (book.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
